// ===== rtl/pqrr_pkg.sv =====
// shared types and constants for the partitioned queue round-robin router
`timescale 1ns / 1ps

package pqrr_pkg;

  // default sizes of the block
  localparam int PARTITIONS_DEF  = 8;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int EVENT_BITS_DEF  = 32;

  // fixed field widths
  localparam int TARGET_BITS   = 3;
  localparam int CFG_PART_BITS = 4;
  localparam int CFG_CAP_BITS  = 5;
  localparam int CFG_DATA_BITS = 5;

  // register reset values
  localparam logic [CFG_PART_BITS-1:0] CFG_PART_RST = 4'd8;
  localparam logic [CFG_CAP_BITS-1:0]  CFG_CAP_RST  = 5'd16;

  // depth of the request queue between front and back, a power of two
  localparam int FIFO_DEPTH = 2;

  // command codes
  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_t;

  // configuration register indexes
  typedef enum logic {
    CFG_PARTITIONS = 1'b0,
    CFG_CAPACITY   = 1'b1
  } cfg_idx_t;

  // head of the request queue as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } fe_req_t;

endpackage

// ===== rtl/pqrr_front.sv =====
// front end: takes requests, maps the target partition and queues them
`timescale 1ns / 1ps

module pqrr_front import pqrr_pkg::*; #(
  parameter int PARTITIONS = PARTITIONS_DEF,
  parameter int EVENT_BITS = EVENT_BITS_DEF,
  parameter int PW         = 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic                   in_command,
  input  logic [TARGET_BITS-1:0] in_target_partition,
  input  logic [EVENT_BITS-1:0]  in_event_in,
  output fe_req_t                req,
  output logic [PW-1:0]          req_part,
  output logic [EVENT_BITS-1:0]  req_event,
  input  logic                   pop
);

  localparam int FAW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FCW = $clog2(FIFO_DEPTH + 1);

  cmd_t                  cmd_q   [FIFO_DEPTH];
  logic [PW-1:0]         part_q  [FIFO_DEPTH];
  logic [EVENT_BITS-1:0] event_q [FIFO_DEPTH];

  logic [FAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FCW-1:0] cnt_r, cnt_nxt;

  logic          push;
  logic          do_pop;
  logic [PW-1:0] part_map;

  // a target beyond the partitions in the build goes to partition 0
  always_comb begin
    if (int'(in_target_partition) >= PARTITIONS) begin
      part_map = '0;
    end else begin
      part_map = PW'(in_target_partition);
    end
  end

  assign busy   = (cnt_r == FCW'(FIFO_DEPTH));
  assign push   = start && !busy;
  assign do_pop = pop && (cnt_r != '0);

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = push   ? wr_ptr_r + FAW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + FAW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + FCW'(1);
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - FCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      cmd_q[wr_ptr_r]   <= cmd_t'(in_command);
      part_q[wr_ptr_r]  <= part_map;
      event_q[wr_ptr_r] <= in_event_in;
    end
  end

  // head of queue
  assign req.valid = (cnt_r != '0);
  assign req.cmd   = cmd_q[rd_ptr_r];
  assign req_part  = part_q[rd_ptr_r];
  assign req_event = event_q[rd_ptr_r];

endmodule

// ===== rtl/pqrr_back.sv =====
// back end: per-partition queues, event store, round-robin search and statistics
`timescale 1ns / 1ps

module pqrr_back import pqrr_pkg::*; #(
  parameter int PARTITIONS  = PARTITIONS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int EVENT_BITS  = EVENT_BITS_DEF,
  parameter int PW          = 1,
  parameter int CW          = 1,
  parameter int TW          = 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [CFG_PART_BITS-1:0] cfg_parts,
  input  logic [CFG_CAP_BITS-1:0]  cfg_cap,
  input  fe_req_t                  req,
  input  logic [PW-1:0]            req_part,
  input  logic [EVENT_BITS-1:0]    req_event,
  output logic                     pop,
  output logic                     out_valid,
  output logic                     out_success,
  output logic [EVENT_BITS-1:0]    out_event_out,
  output logic [TW-1:0]            out_occupancy_total,
  output logic [TW-1:0]            out_peak_occupancy,
  output logic [CW-1:0]            out_peak_partition_count
);

  localparam int AW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NPW = $clog2(PARTITIONS + 1);
  localparam int MD  = PARTITIONS * QUEUE_DEPTH;
  localparam int MW  = (MD > 1) ? $clog2(MD) : 1;

  logic [CW-1:0] cnt_r  [PARTITIONS];
  logic [CW-1:0] cnt_nxt[PARTITIONS];
  logic [AW-1:0] head_r  [PARTITIONS];
  logic [AW-1:0] head_nxt[PARTITIONS];
  logic [AW-1:0] tail_r  [PARTITIONS];
  logic [AW-1:0] tail_nxt[PARTITIONS];

  logic [TW-1:0] total_r, total_nxt;
  logic [TW-1:0] peak_r, peak_nxt;
  logic [CW-1:0] peak_single_r, peak_single_nxt;
  logic [PW-1:0] rr_r, rr_nxt;

  logic [NPW-1:0] rr_wk_r, rr_wk_nxt;
  logic           rr_wk_vld_r, rr_wk_vld_nxt;

  logic out_valid_r, out_valid_nxt;
  logic out_success_r, out_success_nxt;
  logic from_mem_r, from_mem_nxt;

  logic [EVENT_BITS-1:0] event_store[MD];
  logic [EVENT_BITS-1:0] rd_data_r;

  logic [NPW-1:0] np;
  logic [CW-1:0]  cap;
  logic [NPW-1:0] rr_wide;
  logic [NPW-1:0] rr_src;

  logic [PARTITIONS-1:0] busy_mask;
  logic                  found_lo, found_hi;
  logic [PW-1:0]         lo_idx, hi_idx;
  logic                  found;
  logic [PW-1:0]         found_part;

  logic [PW-1:0]  op_part;
  logic [CW-1:0]  cur_cnt;
  logic [CW-1:0]  cnt_inc;
  logic [CW-1:0]  ptr_inc;
  logic [NPW-1:0] part_inc;
  logic [TW-1:0]  total_inc;
  logic           mem_we, mem_re;
  logic [MW-1:0]  mem_addr;

  // effective register values, zero or out of range means the maximum
  always_comb begin
    if (cfg_parts == '0 || int'(cfg_parts) > PARTITIONS) begin
      np = NPW'(PARTITIONS);
    end else begin
      np = NPW'(cfg_parts);
    end
    if (cfg_cap == '0 || int'(cfg_cap) > QUEUE_DEPTH) begin
      cap = CW'(QUEUE_DEPTH);
    end else begin
      cap = CW'(cfg_cap);
    end
  end

  assign rr_wide = NPW'(rr_r);

  // search start: the stored pointer or its partly reduced working copy
  assign rr_src = rr_wk_vld_r ? rr_wk_r : rr_wide;

  // round-robin search: first non-empty partition at or after the pointer, else lowest
  always_comb begin
    found_lo = 1'b0;
    found_hi = 1'b0;
    lo_idx   = '0;
    hi_idx   = '0;
    for (int i = PARTITIONS - 1; i >= 0; i--) begin
      busy_mask[i] = (cnt_r[i] != '0) && (i < int'(np));
      if (busy_mask[i]) begin
        found_lo = 1'b1;
        lo_idx   = PW'(i);
        if (i >= int'(rr_src)) begin
          found_hi = 1'b1;
          hi_idx   = PW'(i);
        end
      end
    end
    found      = found_lo;
    found_part = found_hi ? hi_idx : lo_idx;
  end

  // one partition is touched per request
  always_comb begin
    op_part   = (req.cmd == CMD_ENQ) ? req_part : found_part;
    cur_cnt   = cnt_r[op_part];
    cnt_inc   = cur_cnt + CW'(1);
    total_inc = total_r + TW'(1);
    part_inc  = NPW'(op_part) + NPW'(1);
    if (req.cmd == CMD_ENQ) begin
      ptr_inc = CW'(tail_r[op_part]) + CW'(1);
    end else begin
      ptr_inc = CW'(head_r[op_part]) + CW'(1);
    end
    if (req.cmd == CMD_ENQ) begin
      mem_addr = MW'(int'(op_part) * QUEUE_DEPTH + int'(tail_r[op_part]));
    end else begin
      mem_addr = MW'(int'(op_part) * QUEUE_DEPTH + int'(head_r[op_part]));
    end
  end

  // request execution
  always_comb begin
    cnt_nxt         = cnt_r;
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    total_nxt       = total_r;
    peak_nxt        = peak_r;
    peak_single_nxt = peak_single_r;
    rr_nxt          = rr_r;
    rr_wk_nxt       = rr_wk_r;
    rr_wk_vld_nxt   = rr_wk_vld_r;
    out_valid_nxt   = 1'b0;
    out_success_nxt = 1'b0;
    from_mem_nxt    = 1'b0;
    pop             = 1'b0;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    if (req.valid) begin
      if (req.cmd == CMD_ENQ) begin
        pop           = 1'b1;
        out_valid_nxt = 1'b1;
        if (cur_cnt < cap) begin
          mem_we            = 1'b1;
          tail_nxt[op_part] = (ptr_inc >= cap) ? '0 : AW'(ptr_inc);
          cnt_nxt[op_part]  = cnt_inc;
          total_nxt         = total_inc;
          if (total_inc > peak_r) begin
            peak_nxt = total_inc;
          end
          if (cnt_inc > peak_single_r) begin
            peak_single_nxt = cnt_inc;
          end
          out_success_nxt = 1'b1;
        end
      end else if (rr_src >= np) begin
        // pointer left stale by a smaller partition count: reduce a working copy,
        // the stored pointer only moves on a successful dequeue
        rr_wk_nxt     = rr_src - np;
        rr_wk_vld_nxt = 1'b1;
      end else begin
        pop           = 1'b1;
        out_valid_nxt = 1'b1;
        rr_wk_vld_nxt = 1'b0;
        if (found) begin
          mem_re            = 1'b1;
          head_nxt[op_part] = (ptr_inc >= cap) ? '0 : AW'(ptr_inc);
          cnt_nxt[op_part]  = cur_cnt - CW'(1);
          if (total_r != '0) begin
            total_nxt = total_r - TW'(1);
          end
          rr_nxt          = (part_inc == np) ? '0 : PW'(part_inc);
          out_success_nxt = 1'b1;
          from_mem_nxt    = 1'b1;
        end
      end
    end
  end

  // control and statistics registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PARTITIONS; i++) begin
        cnt_r[i]  <= '0;
        head_r[i] <= '0;
        tail_r[i] <= '0;
      end
      total_r       <= '0;
      peak_r        <= '0;
      peak_single_r <= '0;
      rr_r          <= '0;
      rr_wk_r       <= '0;
      rr_wk_vld_r   <= 1'b0;
      out_valid_r   <= 1'b0;
      out_success_r <= 1'b0;
      from_mem_r    <= 1'b0;
    end else begin
      cnt_r         <= cnt_nxt;
      head_r        <= head_nxt;
      tail_r        <= tail_nxt;
      total_r       <= total_nxt;
      peak_r        <= peak_nxt;
      peak_single_r <= peak_single_nxt;
      rr_r          <= rr_nxt;
      rr_wk_r       <= rr_wk_nxt;
      rr_wk_vld_r   <= rr_wk_vld_nxt;
      out_valid_r   <= out_valid_nxt;
      out_success_r <= out_success_nxt;
      from_mem_r    <= from_mem_nxt;
    end
  end

  // event store, one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      event_store[mem_addr] <= req_event;
    end
    if (mem_re) begin
      rd_data_r <= event_store[mem_addr];
    end
  end

  // result ports
  assign out_valid                = out_valid_r;
  assign out_success              = out_success_r;
  assign out_event_out            = from_mem_r ? rd_data_r : '0;
  assign out_occupancy_total      = total_r;
  assign out_peak_occupancy       = peak_r;
  assign out_peak_partition_count = peak_single_r;

`ifndef ASSERT_OFF
  // a result only follows a request taken from the queue
  a_result_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(pop))
    else $error("result without a popped request");

  // total occupancy never exceeds the store
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(total_r) <= MD)
    else $error("total occupancy above store size");

  // read data is only shown with a successful result
  a_mem_result: assert property (@(posedge clk) disable iff (!rst_n)
    from_mem_r |-> (out_valid_r && out_success_r && $past(mem_re)))
    else $error("event read data shown without a successful dequeue");
`endif

endmodule

// ===== rtl/partitioned_queue_rr_router.sv =====
// Top level of the partitioned queue round-robin router.
// An accepted request is written into the request queue, executed from its head by the
// back end and its result registered. Throughput: one request per cycle while busy is
// low; a dequeue after a partition-count cut waits while the back end reduces the pointer.
// Reset clears all queue pointers, counts, statistics and the request queue; the
// event store is not cleared. Results cannot be stalled by the receiver.
`timescale 1ns / 1ps

module partitioned_queue_rr_router import pqrr_pkg::*; #(
  parameter int PARTITIONS  = PARTITIONS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int EVENT_BITS  = EVENT_BITS_DEF,
  localparam int PW = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1,
  localparam int CW = $clog2(QUEUE_DEPTH + 1),
  localparam int TW = $clog2(PARTITIONS * QUEUE_DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_command,
  input  logic [TARGET_BITS-1:0]   in_target_partition,
  input  logic [EVENT_BITS-1:0]    in_event_in,
  output logic                     out_valid,
  output logic                     out_success,
  output logic [EVENT_BITS-1:0]    out_event_out,
  output logic [TW-1:0]            out_occupancy_total,
  output logic [TW-1:0]            out_peak_occupancy,
  output logic [CW-1:0]            out_peak_partition_count,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  logic [CFG_PART_BITS-1:0] cfg_parts_r;
  logic [CFG_CAP_BITS-1:0]  cfg_cap_r;

  fe_req_t               req;
  logic [PW-1:0]         req_part;
  logic [EVENT_BITS-1:0] req_event;
  logic                  pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_parts_r <= CFG_PART_RST;
      cfg_cap_r   <= CFG_CAP_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PARTITIONS: cfg_parts_r <= cfg_data[CFG_PART_BITS-1:0];
        CFG_CAPACITY:   cfg_cap_r   <= cfg_data[CFG_CAP_BITS-1:0];
        default: begin
          cfg_cap_r <= cfg_cap_r;
        end
      endcase
    end
  end

  // request intake
  pqrr_front #(
    .PARTITIONS(PARTITIONS),
    .EVENT_BITS(EVENT_BITS),
    .PW        (PW)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_command         (in_command),
    .in_target_partition(in_target_partition),
    .in_event_in        (in_event_in),
    .req                (req),
    .req_part           (req_part),
    .req_event          (req_event),
    .pop                (pop)
  );

  // queue execution
  pqrr_back #(
    .PARTITIONS (PARTITIONS),
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .EVENT_BITS (EVENT_BITS),
    .PW         (PW),
    .CW         (CW),
    .TW         (TW)
  ) u_back (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_parts               (cfg_parts_r),
    .cfg_cap                 (cfg_cap_r),
    .req                     (req),
    .req_part                (req_part),
    .req_event               (req_event),
    .pop                     (pop),
    .out_valid               (out_valid),
    .out_success             (out_success),
    .out_event_out           (out_event_out),
    .out_occupancy_total     (out_occupancy_total),
    .out_peak_occupancy      (out_peak_occupancy),
    .out_peak_partition_count(out_peak_partition_count)
  );

endmodule
